### src/tspo_pkg.sv
// ----------------------------------------------------------------------------
// tspo_pkg
// Types, sizes and helpers shared by the timed slot pool.
// ----------------------------------------------------------------------------
package tspo_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int TIME_BITS  = 16;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W      = 9;
  localparam int SERIAL_W   = 32;
  localparam int ALPHA_W    = 8;
  localparam int LIMIT_W    = 5;

  localparam logic [31:0] TIME_MAX32 = 32'((64'd1 << TIME_BITS) - 64'd1);

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TIME_BITS-1:0] tm_t;
  typedef logic [ALPHA_W-1:0]   alpha_t;
  typedef logic [SERIAL_W-1:0]  serial_t;

  typedef enum logic [1:0] {
    K_ADD   = 2'd0,
    K_TICK  = 2'd1,
    K_CLEAR = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    tm_t     age;
    tm_t     life;
    alpha_t  alpha;
    serial_t serial;
  } entry_t;

  typedef struct packed {
    logic   start;
    alpha_t alpha;
    tm_t    life;
    tm_t    age;
  } fade_req_t;

  typedef struct packed {
    logic   done;
    alpha_t opacity;
  } fade_rsp_t;

  function automatic tm_t time_sat(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    if (w > TIME_MAX32) w = TIME_MAX32;
    return w[TIME_BITS-1:0];
  endfunction

endpackage

### src/tspo_if.sv
// ----------------------------------------------------------------------------
// tspo_if
// Valid/ready channels for the request and result items of the slot pool.
// ----------------------------------------------------------------------------
interface tspo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] life_span;
  logic [7:0]  alpha;
  logic [15:0] delta;
  logic [3:0]  slot_index;

  modport source (output valid, kind, life_span, alpha, delta, slot_index, input ready);
  modport sink   (input valid, kind, life_span, alpha, delta, slot_index, output ready);
endinterface

interface tspo_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] slot;
  logic       replaced;
  logic [7:0] opacity;
  logic [4:0] active_count;

  modport source (output valid, slot, replaced, opacity, active_count, input ready);
  modport sink   (input valid, slot, replaced, opacity, active_count, output ready);
endinterface

### src/tspo_fade_unit.sv
// ----------------------------------------------------------------------------
// tspo_fade_unit
// Opacity of a slot: fade window, alpha product, then a bit-serial divide
// by the life span, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tspo_fade_unit import tspo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fade_req_t req,
  output fade_rsp_t rsp
);

  localparam int PROD_W = ALPHA_W + TIME_BITS;
  localparam int STEP_W = (ALPHA_W > 1) ? $clog2(ALPHA_W) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ALPHA_W - 1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_DONE = 4'b1000
  } fstate_t;

  fstate_t           fst_r;
  alpha_t            alpha_r;
  tm_t               life_r;
  tm_t               fade_r;
  tm_t               part_r;
  alpha_t            lo_r;
  alpha_t            q_r;
  logic [STEP_W-1:0] step_r;

  tm_t                rem_c;
  logic [TIME_BITS+2:0] fade5_c;
  tm_t                fade_c;
  logic [PROD_W-1:0]  prod_c;
  logic [TIME_BITS:0] cand_c;
  logic [TIME_BITS:0] diff_c;
  logic               ge_c;
  tm_t                part_nxt;

  always_comb begin
    rem_c    = (req.age >= req.life) ? '0 : req.life - req.age;
    fade5_c  = {1'b0, rem_c, 2'b00} + {3'b000, rem_c};
    fade_c   = (fade5_c > {3'b000, req.life}) ? req.life : fade5_c[TIME_BITS-1:0];
    prod_c   = PROD_W'(alpha_r) * PROD_W'(fade_r);
    cand_c   = {part_r, lo_r[ALPHA_W-1]};
    ge_c     = cand_c >= {1'b0, life_r};
    diff_c   = cand_c - {1'b0, life_r};
    part_nxt = ge_c ? diff_c[TIME_BITS-1:0] : cand_c[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fst_r <= F_IDLE;
    end else begin
      case (fst_r)
        F_IDLE: begin
          if (req.start) begin
            alpha_r <= req.alpha;
            life_r  <= req.life;
            fade_r  <= fade_c;
            if (req.life == '0) begin
              q_r   <= req.alpha;
              fst_r <= F_DONE;
            end else begin
              fst_r <= F_MUL;
            end
          end
        end
        F_MUL: begin
          part_r <= prod_c[PROD_W-1:ALPHA_W];
          lo_r   <= prod_c[ALPHA_W-1:0];
          q_r    <= '0;
          step_r <= '0;
          fst_r  <= F_DIV;
        end
        F_DIV: begin
          part_r <= part_nxt;
          lo_r   <= {lo_r[ALPHA_W-2:0], 1'b0};
          q_r    <= {q_r[ALPHA_W-2:0], ge_c};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) fst_r <= F_DONE;
        end
        F_DONE: begin
          fst_r <= F_IDLE;
        end
        default: begin
          fst_r <= F_IDLE;
        end
      endcase
    end
  end

  assign rsp.done    = (fst_r == F_DONE);
  assign rsp.opacity = q_r;

endmodule

### src/timed_slot_pool_oldest_evict.sv
// ----------------------------------------------------------------------------
// timed_slot_pool_oldest_evict
// Pool of timed slots held in one synchronous memory, walked slot by slot.
// An add that must evict first walks the allocated slots; tick walks all
// POOL_DEPTH slots (one memory read per cycle, write-back per active slot);
// read: memory read, then fade product and 8-step divide unless permanent.
// One item at a time; a finished result may wait in the output register.
// Reset clears all active bits and counters at once; no clearing pass.
// ----------------------------------------------------------------------------
module timed_slot_pool_oldest_evict import tspo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  tspo_in_if.sink            in_ch,
  tspo_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ADD_WR  = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_TICK    = 7'b0001000,
    S_RD_WAIT = 7'b0010000,
    S_RD_FADE = 7'b0100000,
    S_FIN     = 7'b1000000
  } state_t;

  state_t                  state_r;
  logic [LIMIT_W-1:0]      limit_r;
  logic [POOL_DEPTH-1:0]   active_r;
  cnt_t                    active_cnt_r;
  cnt_t                    alloc_r;
  serial_t                 next_serial_r;
  tm_t                     life_r;
  alpha_t                  alpha_r;
  tm_t                     delta_r;
  idx_t                    slot_r;
  logic                    replaced_r;
  alpha_t                  opacity_r;
  cnt_t                    walk_idx_r;
  logic                    walk_pend_r;
  idx_t                    walk_pidx_r;
  serial_t                 best_serial_r;
  idx_t                    best_idx_r;
  logic                    best_vld_r;
  logic                    out_valid_r;
  logic [3:0]              out_slot_r;
  logic                    out_replaced_r;
  logic [7:0]              out_opacity_r;
  logic [4:0]              out_count_r;

  entry_t                  mem [POOL_DEPTH];
  entry_t                  rd_data_r;
  idx_t                    rd_addr;
  logic                    wr_en;
  idx_t                    wr_addr;
  entry_t                  wr_data;

  fade_req_t               fade_req;
  fade_rsp_t               fade_rsp;

  logic                    in_accept;
  logic [CMP_W-1:0]        alloc9;
  logic [CMP_W-1:0]        lim9;
  logic [POOL_DEPTH-1:0]   alloc_mask;
  logic [POOL_DEPTH-1:0]   free_mask;
  logic                    free_any;
  idx_t                    free_pick;
  logic                    rd_ok;
  logic [CMP_W-1:0]        walk_end9;
  logic                    walk_issue;
  logic [TIME_BITS:0]      age_sum;
  tm_t                     age_new;
  logic                    expire;
  logic                    tick_wr;
  logic                    better;
  logic                    out_free;

  always_comb begin
    alloc9 = CMP_W'(alloc_r);
    lim9   = CMP_W'(limit_r);
    if (lim9 == '0) lim9 = CMP_W'(1);
    if (lim9 > CMP_W'(POOL_DEPTH)) lim9 = CMP_W'(POOL_DEPTH);
    for (int i = 0; i < POOL_DEPTH; i++) begin
      alloc_mask[i] = CMP_W'(i) < alloc9;
    end
    free_mask = alloc_mask & ~active_r;
    free_any  = |free_mask;
    free_pick = '0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (free_mask[i]) free_pick = IDX_W'(i);
    end
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign rd_ok = (CMP_W'(in_ch.slot_index) < alloc9) && active_r[IDX_W'(in_ch.slot_index)];

  assign walk_end9  = (state_r == S_TICK) ? CMP_W'(POOL_DEPTH) : alloc9;
  assign walk_issue = CMP_W'(walk_idx_r) < walk_end9;

  assign rd_addr = (state_r == S_IDLE) ? IDX_W'(in_ch.slot_index) : walk_idx_r[IDX_W-1:0];

  always_comb begin
    age_sum = {1'b0, rd_data_r.age} + {1'b0, delta_r};
    age_new = age_sum[TIME_BITS] ? '1 : age_sum[TIME_BITS-1:0];
    expire  = (rd_data_r.life != '0) && (age_new >= rd_data_r.life);
    tick_wr = (state_r == S_TICK) && walk_pend_r && active_r[walk_pidx_r];
    better  = !best_vld_r || (rd_data_r.serial < best_serial_r);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_pidx_r;
    wr_data = rd_data_r;
    if (state_r == S_ADD_WR) begin
      wr_en          = 1'b1;
      wr_addr        = slot_r;
      wr_data.age    = '0;
      wr_data.life   = life_r;
      wr_data.alpha  = alpha_r;
      wr_data.serial = next_serial_r;
    end else if (tick_wr) begin
      wr_en       = 1'b1;
      wr_data.age = age_new;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign fade_req.start = (state_r == S_RD_WAIT);
  assign fade_req.alpha = rd_data_r.alpha;
  assign fade_req.life  = rd_data_r.life;
  assign fade_req.age   = rd_data_r.age;

  tspo_fade_unit u_fade (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fade_req),
    .rsp   (fade_rsp)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      limit_r       <= LIMIT_W'(16);
      active_r      <= '0;
      active_cnt_r  <= '0;
      alloc_r       <= '0;
      next_serial_r <= '0;
      walk_pend_r   <= 1'b0;
      best_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            replaced_r  <= 1'b0;
            opacity_r   <= '0;
            life_r      <= time_sat(in_ch.life_span);
            alpha_r     <= in_ch.alpha;
            delta_r     <= time_sat(in_ch.delta);
            walk_idx_r  <= '0;
            walk_pend_r <= 1'b0;
            best_vld_r  <= 1'b0;
            case (kind_t'(in_ch.kind))
              K_ADD: begin
                if (free_any) begin
                  slot_r  <= free_pick;
                  state_r <= S_ADD_WR;
                end else if (alloc9 < lim9) begin
                  slot_r  <= IDX_W'(alloc_r);
                  alloc_r <= alloc_r + 1'b1;
                  state_r <= S_ADD_WR;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              K_TICK: begin
                slot_r  <= '0;
                state_r <= S_TICK;
              end
              K_CLEAR: begin
                slot_r       <= '0;
                active_r     <= '0;
                active_cnt_r <= '0;
                alloc_r      <= '0;
                state_r      <= S_FIN;
              end
              K_READ: begin
                slot_r  <= '0;
                state_r <= rd_ok ? S_RD_WAIT : S_FIN;
              end
              default: begin
                slot_r  <= '0;
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_ADD_WR: begin
          active_r[slot_r] <= 1'b1;
          if (!replaced_r) active_cnt_r <= active_cnt_r + 1'b1;
          next_serial_r <= next_serial_r + 1'b1;
          state_r       <= S_FIN;
        end
        S_SCAN, S_TICK: begin
          walk_pend_r <= walk_issue;
          walk_pidx_r <= walk_idx_r[IDX_W-1:0];
          if (walk_issue) walk_idx_r <= walk_idx_r + 1'b1;
          if (state_r == S_SCAN) begin
            if (walk_pend_r && better) begin
              best_vld_r    <= 1'b1;
              best_serial_r <= rd_data_r.serial;
              best_idx_r    <= walk_pidx_r;
            end
          end else if (tick_wr && expire) begin
            active_r[walk_pidx_r] <= 1'b0;
            active_cnt_r          <= active_cnt_r - 1'b1;
          end
          if (!walk_issue && !walk_pend_r) begin
            if (state_r == S_SCAN) begin
              slot_r     <= best_idx_r;
              replaced_r <= 1'b1;
              state_r    <= S_ADD_WR;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RD_WAIT: begin
          state_r <= S_RD_FADE;
        end
        S_RD_FADE: begin
          if (fade_rsp.done) begin
            opacity_r <= fade_rsp.opacity;
            state_r   <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_slot_r     <= 4'(slot_r);
            out_replaced_r <= replaced_r;
            out_opacity_r  <= opacity_r;
            out_count_r    <= 5'(active_cnt_r);
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.replaced     = out_replaced_r;
  assign out_ch.opacity      = out_opacity_r;
  assign out_ch.active_count = out_count_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    active_cnt_r == CNT_W'($countones(active_r)))
    else $error("active count out of step with active bits");

  a_active_in_region: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r & ~alloc_mask) == '0)
    else $error("active slot outside allocated region");

  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    alloc9 <= CMP_W'(POOL_DEPTH))
    else $error("allocated count beyond pool depth");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished item not moved to output register");

endmodule
